>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/alo_pkg.sv
// ----------------------------------------------------------------------------
// alo_pkg
// Shared constants and types of the looper with overdub.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alo_pkg;

    localparam int unsigned C_NINE_TENTHS_Q15 = 29491;
    localparam int unsigned C_Q15_HALF        = 16384;
    localparam int unsigned C_WIN_HALF        = 32768;
    localparam int unsigned C_SAT_A           = 27;
    localparam int unsigned C_SAT_B           = 9;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> hw/rtl/alo_ram.sv
// ----------------------------------------------------------------------------
// alo_ram
// Generic synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/alo_div.sv
// ----------------------------------------------------------------------------
// alo_div
// Restoring divider, one quotient bit per cycle, for the soft saturator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alo_div
    import alo_pkg::*;
#(
    parameter int NW = 39,
    parameter int DW = 23,
    parameter int QB = 17
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire [NW-1:0]   i_num,
    input  wire [DW-1:0]   i_den,
    output t_div_stat      o_stat,
    output logic [QB-1:0]  o_quot
);

    localparam int CW = $clog2(QB + 1);

    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dsh;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= NW'(i_den) << (QB - 1);
            o_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            o_quot <= {o_quot[QB-2:0], ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

>>> hw/rtl/audio_looper_overdub.sv
// ----------------------------------------------------------------------------
// audio_looper_overdub
// Sample looper with overdub: loop memory, window wrap, interpolated playback.
// ----------------------------------------------------------------------------
// usage
//   input channel: one audio sample per transfer with window, speed and gates;
//   o_in_stall is high while a received sample waits in the input buffer.
//   output channel: one output sample per input transfer, in order.
//   samples are processed one at a time by a sequencer around the loop RAM.
//   a pass-through sample skips the loop RAM; playback mixes the source with
//   a value interpolated between two loop entries (only the source while the
//   loop is empty); recording and overdub wait on the bit-serial divider of
//   the saturator.
//   the next input transfer is taken while the current sample is processed.
//   reset clears position, length and flags; the loop RAM is not cleared and
//   only entries written by recording are ever read back.
//   when the receiver stalls, the finished sample holds in the output register
//   and the sequencer waits at its last step; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module audio_looper_overdub
    import alo_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire signed [15:0] i_source_sample,
    input  wire [15:0]        i_window_start,
    input  wire [15:0]        i_window_end,
    input  wire signed [15:0] i_play_speed,
    input  wire               i_record_gate,
    input  wire               i_clear_gate,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [15:0] o_out_sample
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRAC_BITS;
    localparam int AW   = $clog2(DEPTH);
    localparam int LW   = AW + 1;
    localparam int PW   = AW + F;
    localparam int NPW  = PW + 2;
    localparam int SPW  = F + 4;
    localparam int EW   = ((S > 16) ? S : 16) + 1;
    localparam int SEW  = ((SPW > 16) ? SPW : 16) + 1;
    localparam int XW   = S + 2;
    localparam int X2W  = S + 3;
    localparam int KW   = S + 6;
    localparam int DW   = S + 7;
    localparam int NW   = 2 * S + 7;
    localparam int QB   = S + 1;
    localparam int MW   = S + 17;
    localparam int M2W  = S + F + 2;
    localparam int SUMW = S + 3;
    localparam int IN_UP  = (S >= 16) ? S - 16 : 0;
    localparam int IN_DN  = (S < 16) ? 16 - S : 0;
    localparam int SP_UP  = (F >= 12) ? F - 12 : 0;
    localparam int SP_DN  = (F < 12) ? 12 - F : 0;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WIN  = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_R0   = 4'd3;
    localparam logic [3:0] S_R1   = 4'd4;
    localparam logic [3:0] S_R2   = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;
    localparam logic [3:0] S_NUM  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_P0   = 4'd9;
    localparam logic [3:0] S_P1   = 4'd10;
    localparam logic [3:0] S_P2   = 4'd11;
    localparam logic [3:0] S_P3   = 4'd12;
    localparam logic [3:0] S_ADV  = 4'd13;

    // input buffer
    logic                r_ib_valid;
    logic signed [15:0]  r_ib_src;
    logic [15:0]         r_ib_ws;
    logic [15:0]         r_ib_we;
    logic signed [15:0]  r_ib_speed;
    logic                r_ib_rec;
    logic                r_ib_clr;

    // working item
    logic [3:0]          r_state;
    logic signed [15:0]  r_src16;
    logic signed [S-1:0] r_src;
    logic [15:0]         r_ws;
    logic [15:0]         r_we;
    logic signed [SPW-1:0] r_speed;
    logic                r_rec;
    logic                r_clr;
    logic                r_pass;
    logic [AW-1:0]       r_sp_idx;
    logic [AW-1:0]       r_ep_idx;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_i0;
    logic [F-1:0]        r_fr;
    logic signed [S-1:0] r_a;
    logic signed [MW-1:0]  r_mul;
    logic signed [M2W-1:0] r_mul2;
    logic signed [XW-1:0]  r_x;
    logic [X2W-1:0]      r_x2;
    logic                r_neg;
    logic signed [S-1:0] r_res;

    // loop state
    logic [PW-1:0]       r_pos;
    logic [LW-1:0]       r_len;
    logic [AW-1:0]       r_last;
    logic                r_empty;
    logic                r_prev_rec;
    logic                r_prev_clr;

    // combinational
    logic signed [EW-1:0]  src_ext;
    logic signed [S-1:0]   src_conv;
    logic signed [SEW-1:0] spd_ext;
    logic signed [SPW-1:0] spd_conv;
    logic [15:0]           win_lo;
    logic [15:0]           win_hi;
    logic [AW+16:0]        prod_lo;
    logic [AW+16:0]        prod_hi;
    logic [PW:0]           span;
    logic [SPW-1:0]        spd_abs;
    logic                  pass;
    logic [AW-1:0]         cur_idx;
    logic [AW-1:0]         nbr_idx;
    logic [S-1:0]          ram_rdata;
    logic [AW-1:0]         ram_raddr;
    logic                  ram_we;
    logic signed [S-1:0]   rd_s;
    logic signed [S:0]     diff;
    logic signed [S:0]     att;
    logic signed [2*XW-1:0] xsq;
    logic [S:0]            x_abs;
    logic [KW-1:0]         sat_k;
    logic [NW-1:0]         sat_num;
    logic [DW-1:0]         sat_den;
    logic                  div_start;
    t_div_stat             div_stat;
    logic [QB-1:0]         div_quot;
    logic signed [S+1:0]   q_signed;
    logic signed [S-1:0]   sat_val;
    logic signed [SUMW-1:0] play_sum;
    logic signed [S-1:0]   play_val;
    logic signed [EW-1:0]  out_ext;
    logic                  out_free;
    logic signed [NPW-1:0] nxt0;
    logic signed [NPW-1:0] nxt1;
    logic signed [NPW-1:0] sp_pos;
    logic signed [NPW-1:0] ep_pos;
    logic signed [NPW-1:0] nxt_pos;
    logic                  pos_in_win;

    localparam logic signed [S+1:0]   ONE_W    = (S + 2)'(1) <<< (S - 1);
    localparam logic signed [SUMW-1:0] ONE_SUM = SUMW'(1) <<< (S - 1);
    localparam logic signed [SPW-1:0] P_ONE    = SPW'(1) <<< F;

    // input buffer and format conversion
    assign o_in_stall = r_ib_valid;
    assign src_ext    = (EW'(r_ib_src) <<< IN_UP) >>> IN_DN;
    assign src_conv   = S'(src_ext);
    assign spd_ext    = (SEW'(r_ib_speed) <<< SP_UP) >>> SP_DN;
    assign spd_conv   = SPW'(spd_ext);

    // window bounds
    assign win_lo  = (r_ws > r_we) ? r_we : r_ws;
    assign win_hi  = (r_ws > r_we) ? r_ws : r_we;
    assign prod_lo = (AW + 17)'(r_last) * (AW + 17)'(win_lo) + (AW + 17)'(C_WIN_HALF);
    assign prod_hi = (AW + 17)'(r_last) * (AW + 17)'(win_hi) + (AW + 17)'(C_WIN_HALF);

    assign span    = {1'b0, r_ep_idx - r_sp_idx, {F{1'b0}}};
    assign spd_abs = r_speed[SPW-1] ? SPW'(-r_speed) : SPW'(r_speed);
    assign pass    = (span <= (PW + 1)'(spd_abs));

    // memory indexes
    assign cur_idx = (r_pos[PW-1:F] > r_last) ? r_last : r_pos[PW-1:F];
    assign nbr_idx = (r_i0 < r_last) ? r_i0 + 1'b1 : r_last;

    always_comb begin
        case (r_state)
            S_R0:    ram_raddr = cur_idx;
            S_P0:    ram_raddr = cur_idx;
            S_P1:    ram_raddr = nbr_idx;
            default: ram_raddr = r_idx;
        endcase
    end

    assign rd_s = signed'(ram_rdata);
    assign diff = (S + 1)'(rd_s) - (S + 1)'(r_a);
    assign att  = (S + 1)'((r_mul + MW'(C_Q15_HALF)) >>> 15);

    // soft saturator
    assign xsq       = (2 * XW)'(r_x) * (2 * XW)'(r_x);
    assign x_abs     = r_x[XW-1] ? (S + 1)'(-r_x) : (S + 1)'(r_x);
    assign sat_k     = (KW'(C_SAT_A) << (S - 1)) + KW'(r_x2);
    assign sat_num   = NW'(x_abs) * NW'(sat_k);
    assign sat_den   = (DW'(C_SAT_A) << (S - 1)) + DW'(C_SAT_B) * DW'(r_x2);
    assign div_start = (r_state == S_NUM);

    always_comb begin
        q_signed = r_neg ? -(S + 2)'(div_quot) : (S + 2)'(div_quot);
        if (q_signed < -ONE_W) begin
            sat_val = S'(-ONE_W);
        end else if (q_signed > ONE_W - 1) begin
            sat_val = S'(ONE_W - 1);
        end else begin
            sat_val = S'(q_signed);
        end
    end

    assign ram_we = (r_state == S_DIV) && div_stat.done;

    // interpolated playback
    always_comb begin
        play_sum = SUMW'(r_src) + SUMW'(r_a) + SUMW'(r_mul2 >>> F);
        if (play_sum < -ONE_SUM) begin
            play_val = S'(-ONE_SUM);
        end else if (play_sum > ONE_SUM - 1) begin
            play_val = S'(ONE_SUM - 1);
        end else begin
            play_val = S'(play_sum);
        end
    end

    // position advance with wrap
    assign sp_pos = NPW'({r_sp_idx, {F{1'b0}}});
    assign ep_pos = NPW'({r_ep_idx, {F{1'b0}}});
    assign nxt0   = signed'(NPW'(r_pos)) + NPW'(r_speed);

    always_comb begin
        if (nxt0 > ep_pos) begin
            nxt1 = sp_pos + (nxt0 - ep_pos);
        end else if (nxt0 < sp_pos) begin
            nxt1 = ep_pos - (sp_pos - nxt0);
        end else begin
            nxt1 = nxt0;
        end
        if (nxt1 < sp_pos) begin
            nxt_pos = sp_pos;
        end else if (nxt1 > ep_pos) begin
            nxt_pos = ep_pos;
        end else begin
            nxt_pos = nxt1;
        end
    end

    assign pos_in_win = (r_pos >= PW'(sp_pos)) && (r_pos <= PW'(ep_pos));

    assign out_ext  = (EW'(r_res) <<< IN_DN) >>> IN_UP;
    assign out_free = !o_out_valid || !i_out_stall;

    alo_ram #(
        .WIDTH (S),
        .DEPTH (DEPTH)
    ) u_loop_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (sat_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    alo_div #(
        .NW (NW),
        .DW (DW),
        .QB (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (sat_num),
        .i_den   (sat_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // input transfer buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib_valid <= 1'b0;
        end else if (i_in_valid && !r_ib_valid) begin
            r_ib_valid <= 1'b1;
        end else if (r_state == S_IDLE) begin
            r_ib_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_ib_valid) begin
            r_ib_src   <= i_source_sample;
            r_ib_ws    <= i_window_start;
            r_ib_we    <= i_window_end;
            r_ib_speed <= i_play_speed;
            r_ib_rec   <= i_record_gate;
            r_ib_clr   <= i_clear_gate;
        end
    end

    // sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_len       <= '0;
            r_last      <= AW'(DEPTH - 1);
            r_empty     <= 1'b1;
            r_prev_rec  <= 1'b0;
            r_prev_clr  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_ib_valid) begin
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (pass) begin
                        r_state <= S_ADV;
                    end else if (r_rec) begin
                        if (r_empty) begin
                            if (!r_prev_rec) begin
                                r_pos <= '0;
                            end
                            if (r_len < LW'(DEPTH)) begin
                                r_len <= r_len + 1'b1;
                            end
                        end
                        r_state <= S_R0;
                    end else begin
                        if (r_clr && !r_prev_clr) begin
                            r_len   <= '0;
                            r_empty <= 1'b1;
                            r_last  <= AW'(DEPTH - 1);
                        end else if (r_prev_rec && r_empty) begin
                            r_last  <= (r_len != '0) ? AW'(r_len - 1'b1) : '0;
                            r_empty <= 1'b0;
                        end
                        r_state <= S_P0;
                    end
                end
                S_R0: begin
                    r_state <= r_empty ? S_SQ : S_R1;
                end
                S_R1: begin
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_ADV;
                    end
                end
                S_P0: begin
                    r_state <= r_empty ? S_ADV : S_P1;
                end
                S_P1: begin
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        r_pos       <= PW'(nxt_pos);
                        r_prev_rec  <= r_rec;
                        r_prev_clr  <= r_clr;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_src16 <= r_ib_src;
                r_src   <= src_conv;
                r_ws    <= r_ib_ws;
                r_we    <= r_ib_we;
                r_speed <= spd_conv;
                r_rec   <= r_ib_rec;
                r_clr   <= r_ib_clr;
            end
            S_WIN: begin
                r_sp_idx <= AW'(prod_lo >> 16);
                r_ep_idx <= AW'(prod_hi >> 16);
            end
            S_DEC: begin
                r_pass <= pass;
                if (!pass && r_rec) begin
                    r_speed <= (r_empty || !r_speed[SPW-1]) ? P_ONE : -P_ONE;
                end
            end
            S_R0: begin
                r_idx <= cur_idx;
                r_x   <= XW'(r_src);
            end
            S_R1: begin
                r_mul <= MW'(rd_s) * MW'(signed'(17'(C_NINE_TENTHS_Q15)));
            end
            S_R2: begin
                r_x <= XW'(r_src) + XW'(att);
            end
            S_SQ: begin
                r_x2 <= X2W'(xsq >>> (S - 1));
            end
            S_NUM: begin
                r_neg <= r_x[XW-1];
            end
            S_DIV: begin
                if (div_stat.done) begin
                    r_res <= sat_val;
                end
            end
            S_P0: begin
                r_i0  <= cur_idx;
                r_fr  <= r_pos[F-1:0];
                r_res <= r_src;
            end
            S_P1: begin
                r_a <= rd_s;
            end
            S_P2: begin
                r_mul2 <= M2W'(diff) * M2W'(signed'({1'b0, r_fr}));
            end
            S_P3: begin
                r_res <= play_val;
            end
            S_ADV: begin
                if (out_free) begin
                    o_out_sample <= r_pass ? r_src16 : 16'(out_ext);
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_IMPLY(a_write_in_loop, ram_we, r_idx <= r_last, "loop write beyond last index")
    `ASSERT_IMPLY(a_div_owned, div_stat.busy, r_state == S_DIV, "divider busy outside its step")
    `ASSERT_CLK(a_pos_in_window, (r_state == S_ADV && out_free) |=> pos_in_win, "position left window")

endmodule

`default_nettype wire
